[design/cdn_pkg.sv]
// Shared types and helpers for the calendar date normalizer.
// Holds the payload structs and the month offset table; no dependencies.
`timescale 1ns / 1ps

package cdn_pkg;

    // One denormal date as it enters the pipeline.
    typedef struct packed {
        logic        [13:0] year_in;
        logic signed [7:0]  month_in;
        logic signed [10:0] day_in;
        logic signed [24:0] time_seconds_in;
    } date_t;

    // Day number and seconds of day between the forward and inverse halves.
    typedef struct packed {
        logic [22:0] day_number;
        logic [16:0] seconds_of_day;
    } day_t;

    // One normalized result.
    typedef struct packed {
        logic [13:0] year_out;
        logic [3:0]  month_out;
        logic [4:0]  day_out;
        logic [16:0] seconds_of_day;
        logic [22:0] day_number;
    } norm_t;

    // Days before a month in the March-based year: floor(30.6001 * k).
    function automatic logic [8:0] month_offset(input logic [3:0] k);
        logic [8:0] f;
        case (k)
            4'd0:    f = 9'd0;
            4'd1:    f = 9'd30;
            4'd2:    f = 9'd61;
            4'd3:    f = 9'd91;
            4'd4:    f = 9'd122;
            4'd5:    f = 9'd153;
            4'd6:    f = 9'd183;
            4'd7:    f = 9'd214;
            4'd8:    f = 9'd244;
            4'd9:    f = 9'd275;
            4'd10:   f = 9'd306;
            4'd11:   f = 9'd336;
            4'd12:   f = 9'd367;
            4'd13:   f = 9'd397;
            4'd14:   f = 9'd428;
            4'd15:   f = 9'd459;
            default: f = 9'd0;
        endcase
        return f;
    endfunction

endpackage

[design/cdn_if.sv]
// Stream interfaces for the calendar date normalizer: date input and result output.
// Each carries valid, ready and the payload fields; no dependencies.
`timescale 1ns / 1ps

interface cdn_date_if;
    logic               valid;
    logic               ready;
    logic        [13:0] year_in;
    logic signed [7:0]  month_in;
    logic signed [10:0] day_in;
    logic signed [24:0] time_seconds_in;

    modport source (output valid, output year_in, output month_in, output day_in,
                    output time_seconds_in, input ready);
    modport sink   (input valid, input year_in, input month_in, input day_in,
                    input time_seconds_in, output ready);
endinterface

interface cdn_norm_if;
    logic        valid;
    logic        ready;
    logic [13:0] year_out;
    logic [3:0]  month_out;
    logic [4:0]  day_out;
    logic [16:0] seconds_of_day;
    logic [22:0] day_number;

    modport source (output valid, output year_out, output month_out, output day_out,
                    output seconds_of_day, output day_number, input ready);
    modport sink   (input valid, input year_out, input month_out, input day_out,
                    input seconds_of_day, input day_number, output ready);
endinterface

[design/cdn_forward.sv]
// Forward half: carries months into the year and builds the Julian day number.
// Four pipeline stages; uses cdn_pkg.
`timescale 1ns / 1ps

module cdn_forward (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           up_valid,
    output logic           up_ready,
    input  cdn_pkg::date_t up_data,
    output logic           dn_valid,
    input  logic           dn_ready,
    output cdn_pkg::day_t  dn_data
);
    import cdn_pkg::*;

    localparam int unsigned STAGES = 4;

    localparam logic signed [9:0]  MONTH_BIAS  = 10'sd131;       // month - 1 + 11 * 12
    localparam logic        [8:0]  DIV12_MUL   = 9'd342;         // ceil(2^12 / 12)
    localparam logic signed [26:0] SEC_BIAS    = 27'sd16848000;  // 195 days of seconds
    localparam logic        [18:0] DIV675_MUL  = 19'd397683;     // ceil(2^28 / 675)
    localparam logic        [18:0] DIV675      = 19'd675;
    localparam logic signed [9:0]  DAY_BIAS    = 10'sd195;
    localparam logic signed [15:0] YEAR_BIAS   = 16'sd11;
    localparam logic signed [15:0] GREG_YEAR   = 16'sd1582;
    localparam logic        [3:0]  GREG_MONTH  = 4'd10;
    localparam logic signed [10:0] GREG_DAY    = 11'sd15;
    localparam logic signed [16:0] EPOCH_YEARS = 17'sd4716;
    localparam logic        [25:0] DAYS_4Y     = 26'd1461;
    localparam logic signed [16:0] CENT_BIAS   = 17'sd100;
    localparam logic        [29:0] DIV100_MUL  = 30'd20972;      // ceil(2^21 / 100)
    localparam logic signed [24:0] JDN_BIAS    = 25'sd1524;

    // Handshake: a stage loads when it is empty or its successor moves on.
    logic [STAGES-1:0] vld_reg;
    logic [STAGES:0]   rdy;
    logic [STAGES-1:0] vin;

    always_comb
    begin
        rdy[STAGES] = dn_ready;
        for (int i = STAGES - 1; i >= 0; i--)
        begin
            rdy[i] = ~vld_reg[i] | rdy[i+1];
        end
        vin[0] = up_valid;
        for (int i = 1; i < STAGES; i++)
        begin
            vin[i] = vld_reg[i-1];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            for (int i = 0; i < STAGES; i++)
            begin
                if (rdy[i])
                begin
                    vld_reg[i] <= vin[i];
                end
            end
        end
    end

    assign up_ready = rdy[0];
    assign dn_valid = vld_reg[STAGES-1];

    // Stage 1: reciprocal multiplies for the month carry and the day split.
    logic signed [9:0]  month_sum;
    logic        [8:0]  t_next;
    logic        [17:0] q12_prod;
    logic        [4:0]  q12_next;
    logic signed [26:0] sec_sum;
    logic        [18:0] v_next;
    logic        [6:0]  sub_next;
    logic        [37:0] qd_prod;
    logic        [8:0]  qd_next;

    always_comb
    begin
        month_sum = 10'(up_data.month_in) + MONTH_BIAS;
        t_next    = month_sum[8:0];
        q12_prod  = 18'(t_next) * 18'(DIV12_MUL);
        q12_next  = q12_prod[16:12];
        sec_sum   = 27'(up_data.time_seconds_in) + SEC_BIAS;
        v_next    = sec_sum[25:7];
        sub_next  = sec_sum[6:0];
        qd_prod   = 38'(v_next) * 38'(DIV675_MUL);
        qd_next   = qd_prod[36:28];
    end

    logic        [13:0] year1_reg;
    logic        [8:0]  t1_reg;
    logic        [4:0]  q12_reg;
    logic signed [10:0] day1_reg;
    logic        [18:0] v_reg;
    logic        [6:0]  sub1_reg;
    logic        [8:0]  qd_reg;

    // Stage 2: month and year after the carry, calendar choice, seconds remainder.
    logic        [8:0]  mul12;
    logic        [8:0]  rdiff;
    logic        [3:0]  month;
    logic signed [15:0] year_c;
    logic               greg_next;
    logic signed [15:0] yy_next;
    logic        [3:0]  mm_next;
    logic        [18:0] qd_mul;
    logic        [18:0] rem_diff;
    logic        [9:0]  rem_next;
    logic signed [9:0]  off_wide;
    logic signed [8:0]  off_next;

    always_comb
    begin
        mul12  = 9'({q12_reg, 3'b000}) + 9'({q12_reg, 2'b00});
        rdiff  = t1_reg - mul12;
        month  = rdiff[3:0] + 4'd1;
        year_c = $signed({2'b00, year1_reg}) + $signed({11'd0, q12_reg}) - YEAR_BIAS;

        greg_next = (year_c > GREG_YEAR) ||
                    ((year_c == GREG_YEAR) &&
                     ((month > GREG_MONTH) || ((month == GREG_MONTH) && (day1_reg >= GREG_DAY))));

        // January and February count as months 13 and 14 of the previous year.
        if (month <= 4'd2)
        begin
            mm_next = month + 4'd12;
            yy_next = year_c - 16'sd1;
        end
        else
        begin
            mm_next = month;
            yy_next = year_c;
        end

        qd_mul   = 19'(qd_reg) * DIV675;
        rem_diff = v_reg - qd_mul;
        rem_next = rem_diff[9:0];
        off_wide = $signed({1'b0, qd_reg}) - DAY_BIAS;
        off_next = off_wide[8:0];
    end

    logic signed [15:0] yy_reg;
    logic        [3:0]  mm2_reg;
    logic signed [10:0] day2_reg;
    logic               greg2_reg;
    logic        [9:0]  rem_reg;
    logic        [6:0]  sub2_reg;
    logic signed [8:0]  off2_reg;

    // Stage 3: days of the full four-year cycles and the century number.
    logic signed [16:0] w_sum;
    logic        [25:0] p_prod;
    logic        [22:0] quart_next;
    logic signed [16:0] c_sum;
    logic        [29:0] c_prod;
    logic        [7:0]  cq_next;
    logic        [16:0] sod_next;

    always_comb
    begin
        w_sum      = 17'(yy_reg) + EPOCH_YEARS;
        p_prod     = 26'(w_sum[14:0]) * DAYS_4Y;
        quart_next = p_prod[24:2];
        c_sum      = 17'(yy_reg) + CENT_BIAS;
        c_prod     = 30'(c_sum[14:0]) * DIV100_MUL;
        cq_next    = c_prod[28:21];
        sod_next   = {rem_reg, sub2_reg};
    end

    logic        [22:0] quart_reg;
    logic        [7:0]  cq_reg;
    logic        [3:0]  mm3_reg;
    logic signed [10:0] day3_reg;
    logic               greg3_reg;
    logic signed [8:0]  off3_reg;
    logic        [16:0] sod3_reg;

    // Stage 4: sum of all day contributions.
    logic signed [8:0]  cen;
    logic signed [9:0]  corr;
    logic signed [24:0] jdn;
    day_t               day_next;

    always_comb
    begin
        cen = $signed({1'b0, cq_reg}) - 9'sd1;
        if (greg3_reg)
        begin
            corr = 10'sd2 - 10'(cen) + 10'(cen >>> 2);
        end
        else
        begin
            corr = 10'sd0;
        end
        jdn = $signed({2'b00, quart_reg})
            + $signed({16'd0, month_offset(mm3_reg + 4'd1)})
            + 25'(day3_reg) + 25'(corr) - JDN_BIAS + 25'(off3_reg);
        day_next.day_number     = jdn[22:0];
        day_next.seconds_of_day = sod3_reg;
    end

    day_t day_reg;

    always_ff @(posedge clk)
    begin
        if (rdy[0])
        begin
            year1_reg <= up_data.year_in;
            t1_reg    <= t_next;
            q12_reg   <= q12_next;
            day1_reg  <= up_data.day_in;
            v_reg     <= v_next;
            sub1_reg  <= sub_next;
            qd_reg    <= qd_next;
        end
        if (rdy[1])
        begin
            yy_reg    <= yy_next;
            mm2_reg   <= mm_next;
            day2_reg  <= day1_reg;
            greg2_reg <= greg_next;
            rem_reg   <= rem_next;
            sub2_reg  <= sub1_reg;
            off2_reg  <= off_next;
        end
        if (rdy[2])
        begin
            quart_reg <= quart_next;
            cq_reg    <= cq_next;
            mm3_reg   <= mm2_reg;
            day3_reg  <= day2_reg;
            greg3_reg <= greg2_reg;
            off3_reg  <= off2_reg;
            sod3_reg  <= sod_next;
        end
        if (rdy[3])
        begin
            day_reg <= day_next;
        end
    end

    assign dn_data = day_reg;

endmodule

[design/cdn_inverse.sv]
// Inverse half: turns a Julian day number back into year, month and day.
// Seven pipeline stages; uses cdn_pkg.
`timescale 1ns / 1ps

module cdn_inverse (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           up_valid,
    output logic           up_ready,
    input  cdn_pkg::day_t  up_data,
    output logic           dn_valid,
    input  logic           dn_ready,
    output cdn_pkg::norm_t dn_data
);
    import cdn_pkg::*;

    localparam int unsigned STAGES = 7;

    localparam logic        [22:0] GREG_JDN    = 23'd2299161;
    localparam logic signed [26:0] ALPHA_BIAS  = 27'sd7468865;
    localparam logic        [7:0]  ALPHA_MUL   = 8'd229;        // floor(2^25 / 146097)
    localparam logic        [24:0] DAYS_400Y   = 25'd146097;
    localparam logic        [24:0] K_BIAS      = 25'd5607;      // 4 * 1524 - 489
    localparam logic        [14:0] DIV1461_MUL = 15'd22966;     // floor(2^25 / 1461)
    localparam logic        [24:0] DAYS_4Y     = 25'd1461;
    localparam logic        [11:0] R_BIAS      = 12'd492;
    localparam logic        [3:0]  FIRST_E     = 4'd4;
    localparam logic        [3:0]  WRAP_E      = 4'd14;
    localparam logic signed [15:0] EPOCH_LATE  = 16'sd4716;
    localparam logic signed [15:0] EPOCH_EARLY = 16'sd4715;

    logic [STAGES-1:0] vld_reg;
    logic [STAGES:0]   rdy;
    logic [STAGES-1:0] vin;

    always_comb
    begin
        rdy[STAGES] = dn_ready;
        for (int i = STAGES - 1; i >= 0; i--)
        begin
            rdy[i] = ~vld_reg[i] | rdy[i+1];
        end
        vin[0] = up_valid;
        for (int i = 1; i < STAGES; i++)
        begin
            vin[i] = vld_reg[i-1];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            for (int i = 0; i < STAGES; i++)
            begin
                if (rdy[i])
                begin
                    vld_reg[i] <= vin[i];
                end
            end
        end
    end

    assign up_ready = rdy[0];
    assign dn_valid = vld_reg[STAGES-1];

    // Stage 1: estimate of the Gregorian century count alpha.
    logic               greg_next;
    logic signed [26:0] x_sum;
    logic        [24:0] x_next;
    logic        [32:0] a_prod;
    logic        [7:0]  a0_next;

    always_comb
    begin
        greg_next = up_data.day_number >= GREG_JDN;
        x_sum     = $signed({2'b00, up_data.day_number, 2'b00}) - ALPHA_BIAS;
        x_next    = greg_next ? x_sum[24:0] : '0;
        a_prod    = 33'(x_next) * 33'(ALPHA_MUL);
        a0_next   = a_prod[32:25];
    end

    logic [22:0] z1_reg;
    logic [16:0] sod1_reg;
    logic        greg1_reg;
    logic [24:0] x_reg;
    logic [7:0]  a0_reg;

    // Stage 2: remainder of the estimate.
    logic [24:0] a_mul;
    logic [24:0] rx_diff;
    logic [18:0] rx_next;

    always_comb
    begin
        a_mul   = 25'(a0_reg) * DAYS_400Y;
        rx_diff = x_reg - a_mul;
        rx_next = rx_diff[18:0];
    end

    logic [22:0] z2_reg;
    logic [16:0] sod2_reg;
    logic        greg2_reg;
    logic [7:0]  a0b_reg;
    logic [18:0] rx_reg;

    // Stage 3: corrected alpha, Julian-calendar day count and the year numerator.
    logic [7:0]  alpha;
    logic [22:0] a_day;
    logic [24:0] k_next;

    always_comb
    begin
        alpha = a0b_reg + 8'(rx_reg >= DAYS_400Y[18:0]);
        if (greg2_reg)
        begin
            a_day = z2_reg + 23'd1 + 23'(alpha) - 23'(alpha[7:2]);
        end
        else
        begin
            a_day = z2_reg;
        end
        k_next = {a_day, 2'b00} + K_BIAS;
    end

    logic [24:0] k_reg;
    logic [22:0] z3_reg;
    logic [16:0] sod3_reg;

    // Stage 4: estimate of the year count.
    logic [39:0] c_prod;
    logic [14:0] c0_next;

    always_comb
    begin
        c_prod  = 40'(k_reg) * 40'(DIV1461_MUL);
        c0_next = c_prod[39:25];
    end

    logic [24:0] k4_reg;
    logic [14:0] c0_reg;
    logic [22:0] z4_reg;
    logic [16:0] sod4_reg;

    // Stage 5: remainder of the year estimate.
    logic [24:0] c_mul;
    logic [24:0] rk_diff;
    logic [11:0] rk_next;

    always_comb
    begin
        c_mul   = 25'(c0_reg) * DAYS_4Y;
        rk_diff = k4_reg - c_mul;
        rk_next = rk_diff[11:0];
    end

    logic [14:0] c05_reg;
    logic [11:0] rk_reg;
    logic [22:0] z5_reg;
    logic [16:0] sod5_reg;

    // Stage 6: final year count and day within the March-based year.
    logic        wrap;
    logic [14:0] c_next;
    logic [11:0] s_val;
    logic [11:0] r_sum;
    logic [8:0]  r_next;

    always_comb
    begin
        wrap   = rk_reg >= DAYS_4Y[11:0];
        c_next = c05_reg + 15'(wrap);
        s_val  = wrap ? (rk_reg - DAYS_4Y[11:0]) : rk_reg;
        r_sum  = 12'(s_val[10:0]) + R_BIAS;
        r_next = r_sum[10:2];
    end

    logic [14:0] c_reg;
    logic [8:0]  r_reg;
    logic [22:0] z6_reg;
    logic [16:0] sod6_reg;

    // Stage 7: month search over the offset table, then day, month and year.
    logic [3:0]         e_val;
    logic [8:0]         day_wide;
    logic [3:0]         mon;
    logic signed [15:0] yr_wide;
    norm_t              out_next;

    always_comb
    begin
        e_val = FIRST_E;
        for (int k = 5; k < 16; k++)
        begin
            if (r_reg > month_offset(4'(k)))
            begin
                e_val = 4'(k);
            end
        end
        day_wide = r_reg - month_offset(e_val);
        mon      = (e_val < WRAP_E) ? (e_val - 4'd1) : (e_val - 4'd13);
        yr_wide  = $signed({1'b0, c_reg}) - ((mon > 4'd2) ? EPOCH_LATE : EPOCH_EARLY);

        out_next.year_out       = yr_wide[13:0];
        out_next.month_out      = mon;
        out_next.day_out        = day_wide[4:0];
        out_next.seconds_of_day = sod6_reg;
        out_next.day_number     = z6_reg;
    end

    norm_t out_reg;

    always_ff @(posedge clk)
    begin
        if (rdy[0])
        begin
            z1_reg    <= up_data.day_number;
            sod1_reg  <= up_data.seconds_of_day;
            greg1_reg <= greg_next;
            x_reg     <= x_next;
            a0_reg    <= a0_next;
        end
        if (rdy[1])
        begin
            z2_reg    <= z1_reg;
            sod2_reg  <= sod1_reg;
            greg2_reg <= greg1_reg;
            a0b_reg   <= a0_reg;
            rx_reg    <= rx_next;
        end
        if (rdy[2])
        begin
            k_reg    <= k_next;
            z3_reg   <= z2_reg;
            sod3_reg <= sod2_reg;
        end
        if (rdy[3])
        begin
            k4_reg   <= k_reg;
            c0_reg   <= c0_next;
            z4_reg   <= z3_reg;
            sod4_reg <= sod3_reg;
        end
        if (rdy[4])
        begin
            c05_reg  <= c0_reg;
            rk_reg   <= rk_next;
            z5_reg   <= z4_reg;
            sod5_reg <= sod4_reg;
        end
        if (rdy[5])
        begin
            c_reg    <= c_next;
            r_reg    <= r_next;
            z6_reg   <= z5_reg;
            sod6_reg <= sod5_reg;
        end
        if (rdy[6])
        begin
            out_reg <= out_next;
        end
    end

    assign dn_data = out_reg;

endmodule

[design/calendar_date_normalizer.sv]
// Top level of the calendar date normalizer: input register, forward and inverse halves.
// Depends on cdn_pkg, cdn_if, cdn_forward and cdn_inverse.
//
// The block takes a possibly denormal date (year, month, day and a signed seconds
// offset, any of which may overflow or go negative) and returns the same instant as a
// normal date: year, month 1..12, day 1..31, seconds of day 0..86399, and the
// chronological Julian day number. Excess months are carried into the year first;
// dates before 1582-10-15 (judged on the carried year and month and the raw day) are
// read in the Julian calendar, later ones get the full Gregorian century correction.
// Negative seconds reach back into earlier days. A year outside 0..16383 comes out as
// the low 14 bits of its two's complement. The block accepts one transaction per
// clock cycle while the output side is ready; each passes one input register, four
// stages for the forward conversion and seven for the inverse. The depth is set by
// the constant divisions, done as reciprocal multiplies, most of them followed in a
// later stage by a remainder step. When the output stalls, empty stages still take
// new transactions until the pipeline is full; the ready path runs combinationally
// from the output ready through every stage.
`timescale 1ns / 1ps

module calendar_date_normalizer (
    input  logic        clk,
    input  logic        rst_n,
    cdn_date_if.sink    date_ch,
    cdn_norm_if.source  norm_ch
);
    import cdn_pkg::*;

    // Input register stage, so the forward multipliers start from a clean flop.
    logic  in_vld_reg;
    date_t date_reg;
    date_t date_next;
    logic  fwd_ready;
    logic  in_ready;

    assign in_ready      = ~in_vld_reg | fwd_ready;
    assign date_ch.ready = in_ready;

    always_comb
    begin
        date_next.year_in         = date_ch.year_in;
        date_next.month_in        = date_ch.month_in;
        date_next.day_in          = date_ch.day_in;
        date_next.time_seconds_in = date_ch.time_seconds_in;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            in_vld_reg <= date_ch.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready)
        begin
            date_reg <= date_next;
        end
    end

    // Forward conversion: date to day number and seconds of day.
    logic  mid_valid;
    logic  mid_ready;
    day_t  mid_data;

    cdn_forward u_forward (
        .clk      (clk),
        .rst_n    (rst_n),
        .up_valid (in_vld_reg),
        .up_ready (fwd_ready),
        .up_data  (date_reg),
        .dn_valid (mid_valid),
        .dn_ready (mid_ready),
        .dn_data  (mid_data)
    );

    // Inverse conversion: day number back to year, month and day.
    norm_t norm_data;
    logic  norm_valid;

    cdn_inverse u_inverse (
        .clk      (clk),
        .rst_n    (rst_n),
        .up_valid (mid_valid),
        .up_ready (mid_ready),
        .up_data  (mid_data),
        .dn_valid (norm_valid),
        .dn_ready (norm_ch.ready),
        .dn_data  (norm_data)
    );

    assign norm_ch.valid          = norm_valid;
    assign norm_ch.year_out       = norm_data.year_out;
    assign norm_ch.month_out      = norm_data.month_out;
    assign norm_ch.day_out        = norm_data.day_out;
    assign norm_ch.seconds_of_day = norm_data.seconds_of_day;
    assign norm_ch.day_number     = norm_data.day_number;

endmodule

[dv/calendar_date_normalizer_tb.sv]
// Self-checking testbench for calendar_date_normalizer: directed and random dates
// with random idling on both streams. Depends on cdn_pkg, cdn_if and the RTL top level.
`timescale 1ns / 1ps

module calendar_date_normalizer_tb;

    import cdn_pkg::*;

    // Day arithmetic constants. The inverse conversion switches to the
    // Gregorian rules at the day number of 1582-10-15.
    localparam longint SECONDS_PER_DAY     = 86400;
    localparam longint GREGORIAN_FIRST_DAY = 2299161;

    // The run is a couple of thousand transactions; even with both sides
    // idling, this bound is far above any correct run, including the
    // pipeline fill and drain.
    localparam int LIMIT_CYCLES = 200000;

    // Cycles to wait after the last result, well above the pipeline latency.
    localparam int DRAIN_CYCLES = 40;

    logic clk;
    logic rst_n;

    cdn_date_if date_ch ();
    cdn_norm_if norm_ch ();

    calendar_date_normalizer u_top (
        .clk     (clk),
        .rst_n   (rst_n),
        .date_ch (date_ch),
        .norm_ch (norm_ch)
    );

    // Normalized dates predicted for every accepted transaction, oldest first.
    norm_t predicted_dates[$];

    int error_count = 0;
    int cycle_count = 0;

    // When set, neither the sender nor the receiver idles.
    bit steady_flow;

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------

    // Integer division that rounds toward minus infinity. The SystemVerilog
    // operator truncates toward zero, which is wrong for negative dates.
    function automatic longint floor_quot(input longint num, input longint den);
        longint q;
        q = num / den;
        if ((num % den != 0) && ((num < 0) != (den < 0)))
            q = q - 1;
        return q;
    endfunction

    // Works out the normalized date for one input transaction. Months are
    // carried into the year, the date becomes a chronological day number
    // (Julian calendar before 1582-10-15, full century correction from then
    // on), the seconds offset is split with floor division, and the day
    // number is turned back into year, month and day. Meeus's decimal
    // constants appear as exact fractions so every floor is exact.
    function automatic norm_t normalize_date(input date_t item);
        longint year_raw;
        longint month_raw;
        longint day_raw;
        longint secs_raw;
        longint month_idx;
        longint year_c;
        longint month_c;
        longint year_m;
        longint month_m;
        longint century;
        longint correction;
        longint day_num;
        longint sec_of_day;
        longint alpha;
        longint a_val;
        longint b_val;
        longint c_val;
        longint d_val;
        longint e_val;
        longint day_val;
        longint month_val;
        longint year_val;
        bit     gregorian;
        norm_t  res;

        year_raw  = longint'(item.year_in);
        month_raw = longint'($signed(item.month_in));
        day_raw   = longint'($signed(item.day_in));
        secs_raw  = longint'($signed(item.time_seconds_in));

        // Carry excess or negative months into the year.
        month_idx = month_raw - 1;
        year_c    = year_raw + floor_quot(month_idx, 12);
        month_c   = month_idx - floor_quot(month_idx, 12) * 12 + 1;

        // The calendar is chosen on the carried year and month and the raw
        // day, so a day that overflows October 1582 still counts as Gregorian.
        gregorian = (year_c > 1582) ||
                    (year_c == 1582 && (month_c > 10 || (month_c == 10 && day_raw >= 15)));

        // January and February count as months 13 and 14 of the year before.
        year_m  = year_c;
        month_m = month_c;
        if (month_m <= 2)
        begin
            month_m = month_m + 12;
            year_m  = year_m - 1;
        end

        correction = 0;
        if (gregorian)
        begin
            century    = floor_quot(year_m, 100);
            correction = 2 - century + floor_quot(century, 4);
        end

        day_num = floor_quot(1461 * (year_m + 4716), 4)
                + floor_quot(306001 * (month_m + 1), 10000)
                + day_raw + correction - 1524;

        // Negative offsets reach back into earlier days.
        day_num    = day_num + floor_quot(secs_raw, SECONDS_PER_DAY);
        sec_of_day = secs_raw - floor_quot(secs_raw, SECONDS_PER_DAY) * SECONDS_PER_DAY;

        // Day number back to a calendar date.
        a_val = day_num;
        if (day_num >= GREGORIAN_FIRST_DAY)
        begin
            alpha = floor_quot(4 * day_num - 7468865, 146097);
            a_val = day_num + 1 + alpha - floor_quot(alpha, 4);
        end
        b_val     = a_val + 1524;
        c_val     = floor_quot(100 * b_val - 12210, 36525);
        d_val     = floor_quot(1461 * c_val, 4);
        e_val     = floor_quot(10000 * (b_val - d_val), 306001);
        day_val   = b_val - d_val - floor_quot(306001 * e_val, 10000);
        month_val = (e_val < 14) ? e_val - 1 : e_val - 13;
        year_val  = (month_val > 2) ? c_val - 4716 : c_val - 4715;

        // Out-of-range years wrap into the low 14 bits.
        res.year_out       = year_val[13:0];
        res.month_out      = month_val[3:0];
        res.day_out        = day_val[4:0];
        res.seconds_of_day = sec_of_day[16:0];
        res.day_number     = day_num[22:0];
        return res;
    endfunction

    // ------------------------------------------------------------------
    // Sender
    // ------------------------------------------------------------------

    // Drives one date and returns at the rising edge where it was accepted.
    // Every call starts at a rising edge. Ready is sampled on the falling
    // edge, where everything driven at the previous rising edge has settled,
    // so the transaction is taken at the edge that follows. The prediction
    // is queued at that falling edge, well ahead of the result.
    task automatic send_date(input int year_v, input int month_v, input int day_v,
                             input int secs_v);
        date_t item;
        int    gap;

        item.year_in         = year_v[13:0];
        item.month_in        = month_v[7:0];
        item.day_in          = day_v[10:0];
        item.time_seconds_in = secs_v[24:0];

        // Random idle cycles with valid low come before the transaction
        // in about one call of seven.
        if (!steady_flow && $urandom_range(99) < 15)
        begin
            gap = $urandom_range(1, 3);
            date_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end

        date_ch.valid           <= 1'b1;
        date_ch.year_in         <= item.year_in;
        date_ch.month_in        <= item.month_in;
        date_ch.day_in          <= item.day_in;
        date_ch.time_seconds_in <= item.time_seconds_in;

        do
            @(negedge clk);
        while (date_ch.ready !== 1'b1);

        predicted_dates.push_back(normalize_date(item));
        @(posedge clk);
    endtask

    // Random dates drawn from several families. Half have every field in its normal
    // range, some sit around the 1582 calendar reform, some are mildly denormal,
    // and the rest are raw bit patterns over the full width of every field.
    task automatic send_random_date();
        int pick;

        pick = $urandom_range(99);
        if (pick < 50)
        begin
            send_date($urandom_range(1, 9999), $urandom_range(1, 12),
                      $urandom_range(1, 31), $urandom_range(0, 86399));
        end
        else if (pick < 62)
        begin
            send_date($urandom_range(1581, 1583),
                      ($urandom_range(1) == 1) ? 10 : $urandom_range(1, 12),
                      $urandom_range(0, 40),
                      int'($urandom_range(0, 172800)) - 86400);
        end
        else if (pick < 82)
        begin
            send_date($urandom_range(1, 9999),
                      int'($urandom_range(0, 72)) - 30,
                      int'($urandom_range(0, 200)) - 100,
                      int'($urandom_range(0, 1728000)) - 864000);
        end
        else
        begin
            send_date($urandom_range(0, 16383), $urandom_range(0, 255),
                      $urandom_range(0, 2047), int'($urandom & 32'h01FF_FFFF));
        end
    endtask

    // ------------------------------------------------------------------
    // Receiver and checker
    // ------------------------------------------------------------------

    // The output side stalls about a quarter of the time unless the steady
    // stretch is running. Ready stays low during reset.
    always @(posedge clk)
    begin
        if (!rst_n)
            norm_ch.ready <= 1'b0;
        else
            norm_ch.ready <= steady_flow || ($urandom_range(99) >= 25);
    end

    task automatic report_mismatch(input string field, input longint want,
                                   input longint got);
        $error("%s: expected %0d, actual %0d", field, want, got);
        error_count++;
    endtask

    // A result is taken at the rising edge that follows a falling edge where
    // valid and ready are both high, so it is checked at that falling edge.
    always @(negedge clk)
    begin
        norm_t want;

        if (rst_n && norm_ch.valid === 1'b1 && norm_ch.ready === 1'b1)
        begin
            if (predicted_dates.size() == 0)
            begin
                $error("result with no pending date: year_out %0d, day_number %0d",
                       norm_ch.year_out, norm_ch.day_number);
                error_count++;
            end
            else
            begin
                want = predicted_dates.pop_front();
                if (norm_ch.year_out !== want.year_out)
                    report_mismatch("year_out", want.year_out, norm_ch.year_out);
                if (norm_ch.month_out !== want.month_out)
                    report_mismatch("month_out", want.month_out, norm_ch.month_out);
                if (norm_ch.day_out !== want.day_out)
                    report_mismatch("day_out", want.day_out, norm_ch.day_out);
                if (norm_ch.seconds_of_day !== want.seconds_of_day)
                    report_mismatch("seconds_of_day", want.seconds_of_day,
                                    norm_ch.seconds_of_day);
                if (norm_ch.day_number !== want.day_number)
                    report_mismatch("day_number", want.day_number, norm_ch.day_number);
            end
        end
    end

    // Watchdog: a hung handshake ends the run as a failure.
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > LIMIT_CYCLES)
        begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Field extremes: smallest and largest values of every field, zero
    // months and days, and offsets of exactly one day and one second.
    task automatic test_field_extremes();
        send_date(1, 1, 1, 0);
        send_date(9999, 12, 31, 86399);
        send_date(0, -128, -1024, -16777216);
        send_date(16383, 127, 1023, 16777215);
        send_date(8192, 0, 0, -1);
        send_date(2024, 13, 0, 86400);
        send_date(2023, -1, 1023, 0);
    endtask

    // The calendar reform: the last Julian day, the skipped days that the
    // Julian rules still accept, the first Gregorian day, an overflowing
    // September day that stays Julian, an overflowing October day that is
    // Gregorian, a month carried into October 1582, and a step back over
    // the switch with a negative offset.
    task automatic test_calendar_switch();
        send_date(1582, 10, 4, 0);
        send_date(1582, 10, 5, 0);
        send_date(1582, 10, 14, 0);
        send_date(1582, 10, 15, 0);
        send_date(1582, 9, 45, 0);
        send_date(1582, 10, 40, 0);
        send_date(1581, 22, 15, 0);
        send_date(1583, -2, 14, 0);
        send_date(1582, 10, 15, -1);
    endtask

    // Leap years in both calendars and negative seconds offsets that reach
    // into earlier days, months and years.
    task automatic test_leap_and_negative_seconds();
        send_date(1900, 2, 29, 0);
        send_date(2000, 2, 29, 0);
        send_date(1500, 2, 29, 0);
        send_date(2000, 1, 1, -86401);
        send_date(2001, 3, 1, -1);
        send_date(1, 1, 1, -86400);
    endtask

    // Normalized years below zero and above 16383 wrap into 14 bits.
    task automatic test_year_wrap();
        send_date(10, -128, 1, 0);
        send_date(16380, 60, 1, 0);
    endtask

    // Random dates with random idling on both sides.
    task automatic test_random_dates(input int count);
        steady_flow = 1'b0;
        repeat (count) send_random_date();
    endtask

    // A long stretch with neither side idling, so the pipeline runs full.
    task automatic test_streaming_dates(input int count);
        steady_flow = 1'b1;
        repeat (count) send_random_date();
        steady_flow = 1'b0;
    endtask

    // ------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------

    initial
    begin
        steady_flow = 1'b0;

        rst_n                   <= 1'b0;
        date_ch.valid           <= 1'b0;
        date_ch.year_in         <= '0;
        date_ch.month_in        <= '0;
        date_ch.day_in          <= '0;
        date_ch.time_seconds_in <= '0;

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_field_extremes();
        test_calendar_switch();
        test_leap_and_negative_seconds();
        test_year_wrap();
        test_random_dates(700);
        test_streaming_dates(400);
        test_random_dates(650);

        date_ch.valid <= 1'b0;

        // Let every predicted result arrive, then watch a while longer for
        // stray results.
        while (predicted_dates.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (error_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

[sim.f]
design/cdn_pkg.sv
design/cdn_if.sv
design/cdn_forward.sv
design/cdn_inverse.sv
design/calendar_date_normalizer.sv
dv/calendar_date_normalizer_tb.sv
